// File: rtl/bcfa_pkg.sv
// ============================================================================
// bcfa_pkg: shared types and codes for the BCD calendar field adjuster
// Field selector codes and the records that move between pipeline stages.
// ============================================================================
package bcfa_pkg;

   // Field selector codes
   localparam logic [2:0] SEL_HOUR    = 3'd0;
   localparam logic [2:0] SEL_MINUTE  = 3'd1;
   localparam logic [2:0] SEL_FORMAT  = 3'd2;
   localparam logic [2:0] SEL_MONTH   = 3'd3;
   localparam logic [2:0] SEL_DAY     = 3'd4;
   localparam logic [2:0] SEL_WEEKDAY = 3'd5;
   localparam logic [2:0] SEL_YEAR    = 3'd6;

   // Command item as taken from the request channel
   typedef struct packed {
      logic       operation;
      logic [2:0] field_select;
      logic [7:0] hour;
      logic [7:0] minute;
      logic [7:0] second;
      logic [5:0] day;
      logic [4:0] month;
      logic [2:0] weekday;
      logic [7:0] year;
   } rec_type;

   // Decode stage result: record plus hour count and day limit
   typedef struct packed {
      rec_type    rec;
      logic [6:0] hour_cnt;
      logic [5:0] day_lim;
   } dec_type;

   // Step stage result: hour as prefix | BCD(num), other fields final
   typedef struct packed {
      logic [7:0] hour_pre;
      logic [6:0] hour_num;
      logic [7:0] minute;
      logic [7:0] second;
      logic [5:0] day;
      logic [4:0] month;
      logic [2:0] weekday;
      logic [7:0] year;
   } stp_type;

   // Final time record
   typedef struct packed {
      logic [7:0] hour;
      logic [7:0] minute;
      logic [7:0] second;
      logic [5:0] day;
      logic [4:0] month;
      logic [2:0] weekday;
      logic [7:0] year;
   } time_type;

endpackage

// File: rtl/bcfa_intf.sv
// ============================================================================
// bcfa request / response channels
// Valid/ready channels carrying the command item and the updated record.
// ============================================================================
interface bcfa_req_if;
   logic       valid;
   logic       ready;
   logic       operation;
   logic [2:0] field_select;
   logic [7:0] hour_in;
   logic [7:0] minute_in;
   logic [7:0] second_in;
   logic [5:0] day_in;
   logic [4:0] month_in;
   logic [2:0] weekday_in;
   logic [7:0] year_in;

   modport source (
      output valid, operation, field_select, hour_in, minute_in, second_in,
             day_in, month_in, weekday_in, year_in,
      input  ready
   );
   modport sink (
      input  valid, operation, field_select, hour_in, minute_in, second_in,
             day_in, month_in, weekday_in, year_in,
      output ready
   );
endinterface

interface bcfa_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] hour_out;
   logic [7:0] minute_out;
   logic [7:0] second_out;
   logic [5:0] day_out;
   logic [4:0] month_out;
   logic [2:0] weekday_out;
   logic [7:0] year_out;

   modport source (
      output valid, hour_out, minute_out, second_out, day_out, month_out,
             weekday_out, year_out,
      input  ready
   );
   modport sink (
      input  valid, hour_out, minute_out, second_out, day_out, month_out,
             weekday_out, year_out,
      output ready
   );
endinterface

// File: rtl/bcfa_decode.sv
// ============================================================================
// bcfa_decode: first pipeline stage
// Turns the hour byte into a 24-hour count and looks up the day limit.
// ============================================================================
module bcfa_decode (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  bcfa_pkg::rec_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output bcfa_pkg::dec_type out_data
);
   import bcfa_pkg::*;

   // Days per month in BCD; months off the table give zero
   function automatic logic [5:0] month_len(input logic [4:0] m);
      logic [5:0] len;
      unique case (m)
         5'h01, 5'h03, 5'h05, 5'h07, 5'h08, 5'h10, 5'h12: len = 6'h31;
         5'h04, 5'h06, 5'h09, 5'h11:                      len = 6'h30;
         5'h02:                                           len = 6'h28;
         default:                                         len = 6'h00;
      endcase
      return len;
   endfunction

   logic       valid_ff, valid_in;
   dec_type    data_ff, data_in;
   logic [5:0] v12;
   logic [6:0] v24;
   logic [6:0] cnt;
   logic       leap;
   logic [1:0] yr_mod4;

   // Hour byte to 24-hour count (digits read as tens*10+units)
   always_comb begin
      v12 = (in_data.hour[4] ? 6'd10 : 6'd0) + {2'b00, in_data.hour[3:0]};
      v24 = {1'b0, in_data.hour[6:4], 3'b000} + {3'b000, in_data.hour[6:4], 1'b0}
            + {3'b000, in_data.hour[3:0]};
      if (in_data.hour[7]) begin
         if (in_data.hour[5]) begin
            cnt = (v12 == 6'd12) ? 7'd12 : {1'b0, v12} + 7'd12;
         end else begin
            cnt = (v12 == 6'd12) ? 7'd0 : {1'b0, v12};
         end
      end else begin
         cnt = v24;
      end
   end

   // Day limit with leap day; year mod 4 from (2*tens + units) mod 4
   always_comb begin
      yr_mod4 = {in_data.year[4], 1'b0} + in_data.year[1:0];
      leap    = (in_data.month == 5'h02) && (yr_mod4 == 2'd0);
      data_in.rec      = in_data;
      data_in.hour_cnt = cnt;
      data_in.day_lim  = month_len(in_data.month) + {5'd0, leap};
   end

   // Stage register
   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// File: rtl/bcfa_step.sv
// ============================================================================
// bcfa_step: second pipeline stage
// Steps the selected field with wrap, or works out the 12/24 toggle.
// ============================================================================
module bcfa_step (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  bcfa_pkg::dec_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output bcfa_pkg::stp_type out_data
);
   import bcfa_pkg::*;

   localparam logic [7:0] HOUR_MIDNIGHT = 8'h92;
   localparam logic [7:0] HOUR_NOON     = 8'hB2;
   localparam logic [7:0] HOUR_PM_BASE  = 8'hA0;
   localparam logic [7:0] HOUR_AM_BASE  = 8'h80;

   // Generic BCD step up with wrap to low
   function automatic logic [7:0] step_up(input logic [7:0] x, input logic [7:0] lim,
                                          input logic [7:0] low);
      logic [7:0] r;
      if (x >= lim || x == 8'h99) begin
         r = low;
      end else if (x[3:0] == 4'h9) begin
         r = {x[7:4] + 4'h1, 4'h0};
      end else begin
         r = x + 8'h01;
      end
      return r;
   endfunction

   // Generic BCD step down with wrap to limit
   function automatic logic [7:0] step_down(input logic [7:0] x, input logic [7:0] lim,
                                            input logic [7:0] low);
      logic [7:0] r;
      if (x <= low || x == 8'h00) begin
         r = lim;
      end else if (x[3:0] == 4'h0) begin
         r = x - 8'h07;
      end else begin
         r = x - 8'h01;
      end
      return r;
   endfunction

   logic       valid_ff, valid_in;
   stp_type    data_ff, data_in;
   rec_type    rec;
   logic [6:0] cnt;
   logic [6:0] w;
   logic       up;
   logic [7:0] step_pre, tog_pre;
   logic [6:0] step_num, tog_num;
   logic [7:0] day_x, day_l, mon_x, wd_x;

   assign rec = in_data.rec;
   assign cnt = in_data.hour_cnt;
   assign up  = rec.operation;

   // Hour step on the 24-hour count, then 12-hour encode if needed
   always_comb begin
      if (up) begin
         w = (cnt >= 7'd23) ? 7'd0 : cnt + 7'd1;
      end else begin
         w = (cnt == 7'd0) ? 7'd23 : cnt - 7'd1;
      end
      step_num = 7'd0;
      if (rec.hour[7]) begin
         if (w == 7'd0) begin
            step_pre = HOUR_MIDNIGHT;
         end else if (w == 7'd12) begin
            step_pre = HOUR_NOON;
         end else if (w > 7'd12) begin
            step_pre = HOUR_PM_BASE;
            step_num = w - 7'd12;
         end else begin
            step_pre = HOUR_AM_BASE;
            step_num = w;
         end
      end else begin
         step_pre = 8'h00;
         step_num = w;
      end
   end

   // 12/24 format toggle
   always_comb begin
      tog_num = 7'd0;
      if (rec.hour[7]) begin
         if (rec.hour[5]) begin
            tog_pre = 8'h00;
            tog_num = cnt;
         end else if (rec.hour[4:0] == 5'h12) begin
            tog_pre = 8'h00;
         end else begin
            tog_pre = {3'b000, rec.hour[4:0]};
         end
      end else if (rec.hour >= 8'h12) begin
         if (cnt == 7'd12) begin
            tog_pre = HOUR_NOON;
         end else begin
            tog_pre = HOUR_PM_BASE;
            tog_num = cnt - 7'd12;
         end
      end else if (rec.hour == 8'h00) begin
         tog_pre = HOUR_MIDNIGHT;
      end else begin
         tog_pre = HOUR_AM_BASE | rec.hour;
      end
   end

   // Field select
   always_comb begin
      day_x = {2'b00, rec.day};
      day_l = {2'b00, in_data.day_lim};
      mon_x = {3'b000, rec.month};
      wd_x  = {5'b00000, rec.weekday};

      data_in.hour_pre = rec.hour;
      data_in.hour_num = 7'd0;
      data_in.minute   = rec.minute;
      data_in.second   = rec.second;
      data_in.day      = rec.day;
      data_in.month    = rec.month;
      data_in.weekday  = rec.weekday;
      data_in.year     = rec.year;

      unique case (rec.field_select)
         SEL_HOUR: begin
            data_in.hour_pre = step_pre;
            data_in.hour_num = step_num;
         end
         SEL_MINUTE: begin
            data_in.minute = up ? step_up(rec.minute, 8'h59, 8'h00)
                                : step_down(rec.minute, 8'h59, 8'h00);
            data_in.second = 8'h00;
         end
         SEL_FORMAT: begin
            data_in.hour_pre = tog_pre;
            data_in.hour_num = tog_num;
         end
         SEL_MONTH: begin
            data_in.month = 5'(up ? step_up(mon_x, 8'h12, 8'h01)
                                  : step_down(mon_x, 8'h12, 8'h01));
         end
         SEL_DAY: begin
            data_in.day = 6'(up ? step_up(day_x, day_l, 8'h01)
                                : step_down(day_x, day_l, 8'h01));
         end
         SEL_WEEKDAY: begin
            data_in.weekday = 3'(up ? step_up(wd_x, 8'h07, 8'h01)
                                    : step_down(wd_x, 8'h07, 8'h01));
         end
         SEL_YEAR: begin
            data_in.year = up ? step_up(rec.year, 8'h99, 8'h00)
                              : step_down(rec.year, 8'h99, 8'h00);
         end
         default: begin
         end
      endcase
   end

   // Stage register
   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// File: rtl/bcfa_encode.sv
// ============================================================================
// bcfa_encode: third pipeline stage and output register
// Converts the hour count to BCD and merges it with the hour prefix.
// ============================================================================
module bcfa_encode (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  bcfa_pkg::stp_type  in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output bcfa_pkg::time_type out_data
);
   import bcfa_pkg::*;

   logic        valid_ff, valid_in;
   time_type    data_ff, data_in;
   logic [14:0] prod;
   logic [3:0]  tens;
   logic [6:0]  units;

   // Divide by ten via reciprocal (x * 205) >> 11, exact for 7-bit values
   always_comb begin
      prod  = {8'd0, in_data.hour_num} * 15'd205;
      tens  = prod[14:11];
      units = in_data.hour_num - ({tens, 3'b000} + {2'b00, tens, 1'b0});

      data_in.hour    = in_data.hour_pre | {tens, units[3:0]};
      data_in.minute  = in_data.minute;
      data_in.second  = in_data.second;
      data_in.day     = in_data.day;
      data_in.month   = in_data.month;
      data_in.weekday = in_data.weekday;
      data_in.year    = in_data.year;
   end

   // Output register
   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// File: rtl/bcd_calendar_field_adjuster_top.sv
// Each request item steps one field of a packed-BCD clock record up or down
// with wrap, or toggles the hour between 12- and 24-hour form, and yields
// exactly one response item holding the whole updated record. The path is a
// three-stage pipeline (decode, step, encode) with a register in each stage;
// a new item can be taken every cycle unless a stall holds it. Each stage
// holds only while its successor is full and stalled, so backpressure on the
// response channel fills the pipeline before the request side stops.
// ============================================================================
// bcd_calendar_field_adjuster_top: BCD calendar field adjuster
// Request channel in, three pipeline stages, response channel out.
// ============================================================================
module bcd_calendar_field_adjuster_top (
   input  logic         clock,
   input  logic         reset,
   bcfa_req_if.sink     req_ch,
   bcfa_rsp_if.source   rsp_ch
);
   import bcfa_pkg::*;

   rec_type  req_rec;
   dec_type  dec_data;
   stp_type  stp_data;
   time_type rsp_rec;
   logic     dec_valid, dec_ready;
   logic     stp_valid, stp_ready;

   // Gather request fields
   always_comb begin
      req_rec.operation    = req_ch.operation;
      req_rec.field_select = req_ch.field_select;
      req_rec.hour         = req_ch.hour_in;
      req_rec.minute       = req_ch.minute_in;
      req_rec.second       = req_ch.second_in;
      req_rec.day          = req_ch.day_in;
      req_rec.month        = req_ch.month_in;
      req_rec.weekday      = req_ch.weekday_in;
      req_rec.year         = req_ch.year_in;
   end

   bcfa_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_ch.valid),
      .in_ready  (req_ch.ready),
      .in_data   (req_rec),
      .out_valid (dec_valid),
      .out_ready (dec_ready),
      .out_data  (dec_data)
   );

   bcfa_step u_step (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dec_valid),
      .in_ready  (dec_ready),
      .in_data   (dec_data),
      .out_valid (stp_valid),
      .out_ready (stp_ready),
      .out_data  (stp_data)
   );

   bcfa_encode u_encode (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (stp_valid),
      .in_ready  (stp_ready),
      .in_data   (stp_data),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_data  (rsp_rec)
   );

   // Drive response fields
   assign rsp_ch.hour_out    = rsp_rec.hour;
   assign rsp_ch.minute_out  = rsp_rec.minute;
   assign rsp_ch.second_out  = rsp_rec.second;
   assign rsp_ch.day_out     = rsp_rec.day;
   assign rsp_ch.month_out   = rsp_rec.month;
   assign rsp_ch.weekday_out = rsp_rec.weekday;
   assign rsp_ch.year_out    = rsp_rec.year;

endmodule
